// ===== rtl/cluster_node_load_balancer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Cluster node load balancer assertion macros
// Shared concurrent check forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_NODE_LOAD_BALANCER_TOP_DEFINES_SVH
`define CLUSTER_NODE_LOAD_BALANCER_TOP_DEFINES_SVH

// Same-cycle implication check
`define CLB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication check
`define CLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// Load balancer package
// Operation and status codes and the table control bundle.
// ----------------------------------------------------------------------------
package clb_pkg;

    localparam logic [2:0] MODE_INIT  = 3'd0;
    localparam logic [2:0] MODE_REG   = 3'd1;
    localparam logic [2:0] MODE_UPD   = 3'd2;
    localparam logic [2:0] MODE_QRY   = 3'd3;
    localparam logic [2:0] MODE_MIG   = 3'd4;
    localparam logic [2:0] MODE_BAL   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_DISABLED = 3'd3;
    localparam logic [2:0] ST_LOCAL    = 3'd4;

    typedef struct packed {
        logic rd_en;
        logic id_we;
        logic ld_we;
        logic act_set;
        logic clr_all;
    } tbl_ctl_t;

endpackage

// ===== rtl/cluster_node_load_balancer_top.sv =====
// Flow from the accepting edge to out_valid: init goes through S_FIN, disabled and
//   unused modes straight to S_DONE; register, update and query read every table
//   entry in turn (S_RD, S_PR) and then S_FIN; migrate does the same without S_FIN.
// Balance adds the serial divide after the walk (S_DST, S_DIV, S_CMP). One request at
//   a time; the next is taken once the result has entered the output register.
// Reset: table empty and inactive, block disabled, local_node = 1.
// ----------------------------------------------------------------------------
// Cluster node load balancer top level
// Node table walked entry by entry under a small sequencer, with a
// serial divider for the balance average.
// ----------------------------------------------------------------------------
`include "cluster_node_load_balancer_top_defines.svh"

module cluster_node_load_balancer_top
    import clb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int LOAD_WIDTH    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] node_id,
    input  logic [15:0] load,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [4:0]  slot,
    output logic [15:0] load_value,
    output logic        migrate_needed,
    output logic [31:0] best_node
);

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int TOTW = LOAD_WIDTH + CNTW;
    localparam int CMPW = TOTW + 4;
    localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PR   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // configuration
    logic [31:0] local_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? local_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_reg <= 32'd1;
        end
        else if (cfg_wr && paddr[2] == 1'b0)
        begin
            local_reg <= pwdata;
        end
    end

    // sequencer state
    logic [2:0]            state_reg, state_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic                  enabled_reg, enabled_next;
    logic [2:0]            mode_reg, mode_next;
    logic [31:0]           id_reg, id_next;
    logic [LOAD_WIDTH-1:0] ld_reg, ld_next;

    // scan accumulators
    logic                  hit_reg, hit_next;
    logic [IDXW-1:0]       hit_idx_reg, hit_idx_next;
    logic [LOAD_WIDTH-1:0] hit_ld_reg, hit_ld_next;
    logic                  free_reg, free_next;
    logic [IDXW-1:0]       free_idx_reg, free_idx_next;
    logic                  loc_reg, loc_next;
    logic [LOAD_WIDTH-1:0] loc_ld_reg, loc_ld_next;
    logic [TOTW-1:0]       tot_reg, tot_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic [31:0]           minl_reg, minl_next;

    // pending result
    logic [2:0]  st_reg, st_next;
    logic [4:0]  slot_reg, slot_next;
    logic [15:0] lval_reg, lval_next;
    logic        mig_reg, mig_next;
    logic [31:0] tgt_reg, tgt_next;

    // result output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  o_st_reg, o_st_next;
    logic [4:0]  o_slot_reg, o_slot_next;
    logic [15:0] o_lval_reg, o_lval_next;
    logic        o_mig_reg, o_mig_next;
    logic [31:0] o_tgt_reg, o_tgt_next;

    // table and divider hookup
    tbl_ctl_t              tctl;
    logic [IDXW-1:0]       wr_addr;
    logic [31:0]           wr_id;
    logic [LOAD_WIDTH-1:0] wr_ld;
    logic [31:0]           rd_id;
    logic [LOAD_WIDTH-1:0] rd_ld;
    logic                  rd_act;
    logic                  div_start;
    logic                  div_done;
    logic [TOTW-1:0]       avg;

    logic                  last;
    logic [LOAD_WIDTH-1:0] mig_ld;
    logic [CMPW-1:0]       avg7;
    logic [CMPW-1:0]       loc10;

    clb_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LOAD_WIDTH    (LOAD_WIDTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tctl),
        .rd_addr (idx_reg),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_ld   (wr_ld),
        .rd_id   (rd_id),
        .rd_ld   (rd_ld),
        .rd_act  (rd_act)
    );

    clb_div #(
        .NUM_W (TOTW),
        .DEN_W (CNTW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tot_reg),
        .den   (cnt_reg),
        .done  (div_done),
        .quo   (avg)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign last     = (idx_reg == IDXW'(TABLE_ENTRIES - 1));

    // migrate: drop the local load, then raise the destination load
    always_comb
    begin
        mig_ld = rd_ld;
        if (rd_id == local_reg && mig_ld != '0)
        begin
            mig_ld = mig_ld - LOAD_WIDTH'(1);
        end
        if (rd_id == id_reg && mig_ld != LOAD_MAX)
        begin
            mig_ld = mig_ld + LOAD_WIDTH'(1);
        end
    end

    // local > floor(7*avg/10)+2  <=>  7*avg < 10*(local-2), local > 2
    assign avg7  = (CMPW'(avg) << 3) - CMPW'(avg);
    assign loc10 = (CMPW'(loc_ld_reg - LOAD_WIDTH'(2)) << 3)
                 + (CMPW'(loc_ld_reg - LOAD_WIDTH'(2)) << 1);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        enabled_next  = enabled_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        ld_next       = ld_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ld_next   = hit_ld_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        loc_next      = loc_reg;
        loc_ld_next   = loc_ld_reg;
        tot_next      = tot_reg;
        cnt_next      = cnt_reg;
        minl_next     = minl_reg;
        st_next       = st_reg;
        slot_next     = slot_reg;
        lval_next     = lval_reg;
        mig_next      = mig_reg;
        tgt_next      = tgt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_st_next     = o_st_reg;
        o_slot_next   = o_slot_reg;
        o_lval_next   = o_lval_reg;
        o_mig_next    = o_mig_reg;
        o_tgt_next    = o_tgt_reg;
        tctl          = '0;
        wr_addr       = idx_reg;
        wr_id         = id_reg;
        wr_ld         = '0;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // latch the request and clear the scan state
                    mode_next  = mode;
                    id_next    = node_id;
                    ld_next    = LOAD_WIDTH'(load);
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    loc_next   = 1'b0;
                    loc_ld_next = '0;
                    tot_next   = '0;
                    cnt_next   = '0;
                    minl_next  = '1;
                    st_next    = ST_OK;
                    slot_next  = '0;
                    lval_next  = '0;
                    mig_next   = 1'b0;
                    tgt_next   = local_reg;
                    unique case (mode)
                        MODE_INIT:
                        begin
                            state_next = S_FIN;
                        end
                        MODE_REG, MODE_UPD, MODE_QRY:
                        begin
                            state_next = S_RD;
                        end
                        MODE_MIG:
                        begin
                            if (!enabled_reg)
                            begin
                                st_next    = ST_DISABLED;
                                state_next = S_DONE;
                            end
                            else if (node_id == local_reg)
                            begin
                                st_next    = ST_LOCAL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        MODE_BAL:
                        begin
                            if (!enabled_reg)
                            begin
                                st_next    = ST_DISABLED;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                tctl.rd_en = 1'b1;
                state_next = S_PR;
            end

            S_PR:
            begin
                unique case (mode_reg)
                    MODE_MIG:
                    begin
                        tctl.ld_we = 1'b1;
                        wr_ld      = mig_ld;
                    end
                    MODE_BAL:
                    begin
                        if (rd_id == local_reg && !loc_reg)
                        begin
                            loc_next    = 1'b1;
                            loc_ld_next = rd_ld;
                        end
                        if (rd_act)
                        begin
                            tot_next = tot_reg + TOTW'(rd_ld);
                            cnt_next = cnt_reg + CNTW'(1);
                            if (32'(rd_ld) < minl_reg)
                            begin
                                minl_next = 32'(rd_ld);
                                tgt_next  = rd_id;
                            end
                        end
                    end
                    default:
                    begin
                        if (rd_act && rd_id == id_reg && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                            hit_ld_next  = rd_ld;
                        end
                        if (!rd_act && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                endcase
                if (last)
                begin
                    unique case (mode_reg)
                        MODE_MIG: state_next = S_DONE;
                        MODE_BAL: state_next = S_DST;
                        default:  state_next = S_FIN;
                    endcase
                end
                else
                begin
                    idx_next   = idx_reg + IDXW'(1);
                    state_next = S_RD;
                end
            end

            S_FIN:
            begin
                state_next = S_DONE;
                unique case (mode_reg)
                    MODE_INIT:
                    begin
                        // clear marks and loads, install the local node
                        tctl.clr_all = 1'b1;
                        tctl.id_we   = 1'b1;
                        tctl.act_set = 1'b1;
                        wr_addr      = '0;
                        wr_id        = local_reg;
                        enabled_next = 1'b1;
                    end
                    MODE_REG:
                    begin
                        if (hit_reg)
                        begin
                            slot_next = 5'(hit_idx_reg);
                        end
                        else if (free_reg)
                        begin
                            tctl.id_we   = 1'b1;
                            tctl.ld_we   = 1'b1;
                            tctl.act_set = 1'b1;
                            wr_addr      = free_idx_reg;
                            slot_next    = 5'(free_idx_reg);
                        end
                        else
                        begin
                            st_next = ST_FULL;
                        end
                    end
                    MODE_UPD:
                    begin
                        if (hit_reg)
                        begin
                            tctl.ld_we = 1'b1;
                            wr_addr    = hit_idx_reg;
                            wr_ld      = ld_reg;
                            slot_next  = 5'(hit_idx_reg);
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            slot_next = 5'(hit_idx_reg);
                            lval_next = 16'(hit_ld_reg);
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                endcase
            end

            S_DST:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                mig_next   = (loc_ld_reg > LOAD_WIDTH'(2)) && (avg7 < loc10)
                             && (tgt_reg != local_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_st_next      = st_reg;
                    o_slot_next    = slot_reg;
                    o_lval_next    = lval_reg;
                    o_mig_next     = mig_reg;
                    o_tgt_next     = tgt_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        ld_reg       <= ld_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ld_reg   <= hit_ld_next;
        free_idx_reg <= free_idx_next;
        loc_ld_reg   <= loc_ld_next;
        tot_reg      <= tot_next;
        minl_reg     <= minl_next;
        st_reg       <= st_next;
        slot_reg     <= slot_next;
        lval_reg     <= lval_next;
        mig_reg      <= mig_next;
        tgt_reg      <= tgt_next;
        o_st_reg     <= o_st_next;
        o_slot_reg   <= o_slot_next;
        o_lval_reg   <= o_lval_next;
        o_mig_reg    <= o_mig_next;
        o_tgt_reg    <= o_tgt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            enabled_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            loc_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            enabled_reg   <= enabled_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            loc_reg       <= loc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_st_reg;
    assign slot           = o_slot_reg;
    assign load_value     = o_lval_reg;
    assign migrate_needed = o_mig_reg;
    assign best_node      = o_tgt_reg;

    // accepted request leaves the block busy in the next cycle
    `CLB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // migration verdict never points back at the local node
    `CLB_ASSERT_SAME(a_mig_remote, out_valid && migrate_needed, best_node != local_reg)
    // divider only runs for balance with a nonzero active count
    `CLB_ASSERT_SAME(a_div_start, div_start, mode_reg == MODE_BAL && cnt_reg != '0 && enabled_reg)

endmodule

// ===== rtl/clb_table.sv =====
// ----------------------------------------------------------------------------
// Load balancer node table
// Id and load memories with registered read, plus per-entry valid and
// active bits.
// ----------------------------------------------------------------------------
module clb_table
    import clb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int LOAD_WIDTH    = 16,
    localparam int IDXW         = $clog2(TABLE_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbl_ctl_t              ctl,
    input  logic [IDXW-1:0]       rd_addr,
    input  logic [IDXW-1:0]       wr_addr,
    input  logic [31:0]           wr_id,
    input  logic [LOAD_WIDTH-1:0] wr_ld,
    output logic [31:0]           rd_id,
    output logic [LOAD_WIDTH-1:0] rd_ld,
    output logic                  rd_act
);

    logic [31:0]              id_mem [TABLE_ENTRIES];
    logic [LOAD_WIDTH-1:0]    ld_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] id_vld_reg;
    logic [TABLE_ENTRIES-1:0] id_vld_next;
    logic [TABLE_ENTRIES-1:0] ld_vld_reg;
    logic [TABLE_ENTRIES-1:0] ld_vld_next;
    logic [TABLE_ENTRIES-1:0] act_reg;
    logic [TABLE_ENTRIES-1:0] act_next;
    logic [31:0]              rd_id_reg;
    logic [LOAD_WIDTH-1:0]    rd_ld_reg;
    logic                     rd_idv_reg;
    logic                     rd_ldv_reg;
    logic                     rd_act_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (ctl.ld_we)
        begin
            ld_mem[wr_addr] <= wr_ld;
        end
        if (ctl.rd_en)
        begin
            rd_id_reg <= id_mem[rd_addr];
            rd_ld_reg <= ld_mem[rd_addr];
        end
    end

    // clear first, then mark the written entry
    always_comb
    begin
        id_vld_next = id_vld_reg;
        ld_vld_next = ld_vld_reg;
        act_next    = act_reg;
        if (ctl.clr_all)
        begin
            ld_vld_next = '0;
            act_next    = '0;
        end
        if (ctl.id_we)
        begin
            id_vld_next[wr_addr] = 1'b1;
        end
        if (ctl.ld_we)
        begin
            ld_vld_next[wr_addr] = 1'b1;
        end
        if (ctl.act_set)
        begin
            act_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_vld_reg <= '0;
            ld_vld_reg <= '0;
            act_reg    <= '0;
            rd_idv_reg <= 1'b0;
            rd_ldv_reg <= 1'b0;
            rd_act_reg <= 1'b0;
        end
        else
        begin
            id_vld_reg <= id_vld_next;
            ld_vld_reg <= ld_vld_next;
            act_reg    <= act_next;
            if (ctl.rd_en)
            begin
                rd_idv_reg <= id_vld_reg[rd_addr];
                rd_ldv_reg <= ld_vld_reg[rd_addr];
                rd_act_reg <= act_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_id  = rd_idv_reg ? rd_id_reg : '0;
    assign rd_ld  = rd_ldv_reg ? rd_ld_reg : '0;
    assign rd_act = rd_act_reg;

endmodule

// ===== rtl/clb_div.sv =====
// ----------------------------------------------------------------------------
// Load balancer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clb_div
    import clb_pkg::*;
#(
    parameter int NUM_W = 22,
    parameter int DEN_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== test/cluster_node_load_balancer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Cluster node load balancer testbench
// Drives table requests with bursty valid and a stalling receiver, predicts
// each result from a shadow node table, and compares every result field.
// ----------------------------------------------------------------------------
module cluster_node_load_balancer_top_tb
    import clb_pkg::*;
();

    localparam int ENTRIES = 32;
    localparam int RAND_REQS = 1900;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] load_value;
        logic        migrate_needed;
        logic [31:0] best_node;
    } lb_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] node_id;
        logic [15:0] load;
        logic        has_fixed;
        lb_result_t  fixed;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [31:0] node_id;
    logic [15:0] load;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [15:0] load_value;
    logic        migrate_needed;
    logic [31:0] best_node;

    // shadow of the node table
    logic [31:0] sh_local;
    logic [31:0] sh_ids [ENTRIES];
    logic [15:0] sh_loads [ENTRIES];
    logic        sh_active [ENTRIES];
    logic        sh_enabled;

    lb_result_t  pending_results [$];
    int          error_count;
    bit          hold_off;     // long receiver hold-off requested
    bit          stim_done;

    cluster_node_load_balancer_top uut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Compute the result of one request and advance the shadow table.
    function automatic lb_result_t predict_node_op(input logic [2:0] op,
                                                   input logic [31:0] id,
                                                   input logic [15:0] ld);
        lb_result_t r;
        int hit;
        logic [15:0] own_load;
        logic [15:0] least_load;
        logic [63:0] total;
        logic [63:0] cnt;
        logic [63:0] avg;
        logic [63:0] thr;
        logic found_min;
        r = '0;
        r.best_node = sh_local;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && sh_active[i] && sh_ids[i] == id)
                hit = i;
        end
        case (op)
            MODE_INIT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    sh_active[i] = 1'b0;
                    sh_loads[i] = '0;
                end
                sh_ids[0] = sh_local;
                sh_active[0] = 1'b1;
                sh_enabled = 1'b1;
            end
            MODE_REG:
            begin
                if (hit < 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit < 0 && !sh_active[i])
                        begin
                            sh_ids[i] = id;
                            sh_active[i] = 1'b1;
                            sh_loads[i] = '0;
                            hit = i;
                        end
                    end
                end
                if (hit < 0)
                    r.status = ST_FULL;
                else
                    r.slot = hit[4:0];
            end
            MODE_UPD, MODE_QRY:
            begin
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    r.slot = hit[4:0];
                    if (op == MODE_UPD)
                        sh_loads[hit] = ld;
                    else
                        r.load_value = sh_loads[hit];
                end
            end
            MODE_MIG:
            begin
                if (!sh_enabled)
                    r.status = ST_DISABLED;
                else if (id == sh_local)
                    r.status = ST_LOCAL;
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (sh_ids[i] == sh_local && sh_loads[i] != 0)
                            sh_loads[i]--;
                        if (sh_ids[i] == id && sh_loads[i] != 16'hFFFF)
                            sh_loads[i]++;
                    end
                end
            end
            MODE_BAL:
            begin
                if (!sh_enabled)
                    r.status = ST_DISABLED;
                else
                begin
                    own_load = '0;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                    begin
                        if (sh_ids[i] == sh_local)
                            own_load = sh_loads[i];
                    end
                    total = '0;
                    cnt = '0;
                    least_load = '0;
                    found_min = 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (sh_active[i])
                        begin
                            total += sh_loads[i];
                            cnt++;
                            if (!found_min || sh_loads[i] < least_load)
                            begin
                                found_min = 1'b1;
                                least_load = sh_loads[i];
                                r.best_node = sh_ids[i];
                            end
                        end
                    end
                    if (cnt != 0)
                    begin
                        avg = total / cnt;
                        thr = (7 * avg) / 10 + 2;
                        if (own_load > thr && r.best_node != sh_local)
                            r.migrate_needed = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Write the local node id through the configuration port (block idle).
    task automatic write_local_node(input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_local = val;
    endtask

    // Offer one request; hold valid and payload until accepted.
    task automatic send_request(input logic [2:0] op, input logic [31:0] id,
                                input logic [15:0] ld, input logic has_fixed,
                                input lb_result_t fixed);
        lb_result_t r;
        in_valid <= 1'b1;
        mode <= op;
        node_id <= id;
        load <= ld;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_node_op(op, id, ld);
        if (has_fixed && r != fixed)
        begin
            $display("%0t directed row disagrees: expected %h actual %h",
                     $time, fixed, r);
            error_count++;
        end
        pending_results.push_back(r);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected result has come, plus the block's latency.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0, 1, 2: return sh_local;
            3: return $urandom();
            default: return 32'(100 + $urandom_range(0, 40));
        endcase
    endfunction

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        lb_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time,
                         {status, slot, load_value, migrate_needed, best_node});
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, status);
                    error_count++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t slot: expected %0d actual %0d", $time,
                             want.slot, slot);
                    error_count++;
                end
                if (load_value !== want.load_value)
                begin
                    $display("%0t load_value: expected %0d actual %0d", $time,
                             want.load_value, load_value);
                    error_count++;
                end
                if (migrate_needed !== want.migrate_needed)
                begin
                    $display("%0t migrate_needed: expected %0d actual %0d", $time,
                             want.migrate_needed, migrate_needed);
                    error_count++;
                end
                if (best_node !== want.best_node)
                begin
                    $display("%0t best_node: expected %h actual %h", $time,
                             want.best_node, best_node);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stall on its own pattern; a long hold-off on request.
    initial
    begin
        int hold_cycles;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 600)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_off = 1'b0;
            end
            else if (stim_done || ($urandom_range(0, 7) < 5))
                out_ready <= 1'b1;
            else
                out_ready <= 1'b0;
        end
    end

    // Run limit.
    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        req_row_t rows [$];
        lb_result_t fx;
        int burst;
        logic [2:0] op;
        logic [31:0] id;
        logic [15:0] ld;
        logic [31:0] local_settings [4];

        error_count = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        mode <= MODE_INIT;
        node_id <= '0;
        load <= '0;
        sh_local = 32'd1;
        sh_enabled = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sh_ids[i] = '0;
            sh_loads[i] = '0;
            sh_active[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table: disabled and other pre-init cases first, then the cases after init.
        fx = '0;
        fx.status = ST_DISABLED;
        fx.best_node = 32'd1;
        rows.push_back('{MODE_MIG, 32'd5, 16'd0, 1'b1, fx});
        rows.push_back('{MODE_BAL, 32'd0, 16'd0, 1'b1, fx});
        fx = '0;
        fx.status = ST_NOTFOUND;
        fx.best_node = 32'd1;
        rows.push_back('{MODE_QRY, 32'd0, 16'd0, 1'b1, fx});
        rows.push_back('{MODE_UPD, 32'hFFFFFFFF, 16'hFFFF, 1'b1, fx});
        fx = '0;
        fx.best_node = 32'd1;
        rows.push_back('{MODE_REG, 32'hFFFFFFFF, 16'h0, 1'b1, fx});
        rows.push_back('{3'd6, 32'hFFFFFFFF, 16'hFFFF, 1'b1, fx});
        rows.push_back('{3'd7, 32'h0, 16'h0, 1'b1, fx});
        rows.push_back('{MODE_INIT, 32'h0, 16'h0, 1'b1, fx});
        fx.status = ST_LOCAL;
        rows.push_back('{MODE_MIG, 32'd1, 16'd0, 1'b1, fx});
        rows.push_back('{MODE_REG, 32'd7, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_UPD, 32'd7, 16'hFFFF, 1'b0, fx});
        rows.push_back('{MODE_MIG, 32'd7, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_QRY, 32'd7, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_UPD, 32'd1, 16'd40, 1'b0, fx});
        rows.push_back('{MODE_BAL, 32'd0, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_UPD, 32'd7, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_BAL, 32'd0, 16'd0, 1'b0, fx});
        rows.push_back('{MODE_MIG, 32'd9, 16'd0, 1'b0, fx});
        for (int k = 0; k < 6; k++)
            rows.push_back('{MODE_REG, 32'(200 + k), 16'd0, 1'b0, fx});
        foreach (rows[k])
            send_request(rows[k].mode, rows[k].node_id, rows[k].load,
                         rows[k].has_fixed, rows[k].fixed);
        drop_valid();
        drain_results();

        // Fill the table to overflow so table full is reached.
        for (int k = 0; k < 34; k++)
            send_request(MODE_REG, 32'(300 + k), 16'd0, 1'b0, fx);
        drop_valid();
        drain_results();

        // Random phases, each under a different local node id.
        local_settings[0] = 32'h0;
        local_settings[1] = 32'hFFFFFFFF;
        local_settings[2] = 32'd1;
        local_settings[3] = $urandom();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_local_node(local_settings[ph]);
            send_request(MODE_INIT, $urandom(), 16'($urandom()), 1'b0, fx);
            if (ph == 1)
                hold_off = 1'b1;   // back up the block while requests keep coming
            for (int n = 0; n < RAND_REQS / 4; n += burst)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++)
                begin
                    case ($urandom_range(0, 19))
                        0: op = MODE_INIT;
                        1, 2, 3, 4: op = MODE_REG;
                        5, 6, 7, 8: op = MODE_UPD;
                        9, 10, 11: op = MODE_QRY;
                        12, 13, 14, 15: op = MODE_MIG;
                        16, 17, 18: op = MODE_BAL;
                        default: op = 3'($urandom_range(6, 7));
                    endcase
                    id = pick_id();
                    ld = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 60));
                    send_request(op, id, ld, 1'b0, fx);
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            drop_valid();
            drain_results();
        end

        stim_done = 1'b1;
        drain_results();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
